// ===== sv/qtl_pkg.sv =====
package qtl_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);
	localparam int QCW         = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_DOLL = 8'h24;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_W    = 8'h57;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [4:0] HEX_BASE = 5'd16;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_AT   = 2'd1,
		MODE_NUM  = 2'd2
	} lex_mode_t;

	typedef enum logic [3:0] {
		TK_READ    = 4'd0,
		TK_WRITE   = 4'd1,
		TK_DESC    = 4'd2,
		TK_ATTR    = 4'd3,
		TK_NUMBER  = 4'd4,
		TK_LIST    = 4'd5,
		TK_SEMI    = 4'd6,
		TK_END     = 4'd7,
		TK_ERR     = 4'd8,
		TK_READERR = 4'd9
	} token_kind_t;

	typedef struct packed {
		logic                 ok;
		logic [3:0]           value;
	} hex_t;

	typedef struct packed {
		logic [1:0]           cnt;
		token_kind_t          kind0;
		token_kind_t          kind1;
		logic [OUT_WIDTH-1:0] value;
	} entry_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		logic [7:0] d;
		h = '0;
		d = '0;
		if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30;
			h.ok = 1'b1;
		end else if (c inside {[8'h41:8'h46]}) begin
			d = c - 8'h41 + 8'(HEX_BASE) - 8'd6;
			h.ok = 1'b1;
		end else if (c inside {[8'h61:8'h66]}) begin
			d = c - 8'h61 + 8'(HEX_BASE) - 8'd6;
			h.ok = 1'b1;
		end
		h.value = d[3:0];
		return h;
	endfunction

	function automatic logic [OUT_WIDTH-1:0] to_out(input logic [VALUE_WIDTH-1:0] acc);
		logic [63:0] wide;
		wide = 64'(acc);
		return wide[OUT_WIDTH-1:0];
	endfunction

endpackage

// ===== sv/qtl_front.sv =====
module qtl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_stall,
	input  logic [7:0]      char_code,
	input  logic            read_failed,
	input  logic            q_full,
	output logic            q_push,
	output qtl_pkg::entry_t q_entry
);
	import qtl_pkg::*;

	lex_mode_t              mode_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	lex_mode_t              nxt_mode;
	logic [VALUE_WIDTH-1:0] nxt_acc;
	entry_t                 ent;
	hex_t                   hd;
	lex_mode_t              f_mode;
	logic                   f_has;
	token_kind_t            f_kind;
	logic                   accept;

	assign char_stall = q_full;
	assign accept     = char_valid && !char_stall;
	assign hd         = hex_digit(char_code);

	always_comb begin
		f_mode = MODE_IDLE;
		f_has  = 1'b1;
		f_kind = TK_ERR;
		if (hd.ok) begin
			f_mode = MODE_NUM;
			f_has  = 1'b0;
		end else begin
			case (char_code)
				CH_AT: begin
					f_mode = MODE_AT;
					f_has  = 1'b0;
				end
				CH_NL:   f_kind = TK_END;
				CH_HASH: f_kind = TK_DESC;
				CH_DOLL: f_kind = TK_ATTR;
				CH_SEMI: f_kind = TK_SEMI;
				default: f_kind = TK_ERR;
			endcase
		end
	end

	always_comb begin
		nxt_mode  = mode_q;
		nxt_acc   = acc_q;
		ent.cnt   = 2'd0;
		ent.kind0 = TK_ERR;
		ent.kind1 = TK_READERR;
		ent.value = '0;
		if (read_failed) begin
			nxt_mode = MODE_IDLE;
			case (mode_q)
				MODE_NUM: begin
					ent.cnt   = 2'd2;
					ent.kind0 = TK_NUMBER;
					ent.value = to_out(acc_q);
				end
				MODE_AT: begin
					ent.cnt   = 2'd2;
					ent.kind0 = TK_ERR;
				end
				default: begin
					ent.cnt   = 2'd1;
					ent.kind0 = TK_READERR;
				end
			endcase
		end else begin
			case (mode_q)
				MODE_AT: begin
					nxt_mode = MODE_IDLE;
					ent.cnt  = 2'd1;
					case (char_code)
						CH_R:    ent.kind0 = TK_READ;
						CH_W:    ent.kind0 = TK_WRITE;
						CH_AT:   ent.kind0 = TK_LIST;
						default: begin
							ent.kind0 = TK_ERR;
							ent.kind1 = f_kind;
							ent.cnt   = 2'd1 + {1'b0, f_has};
							nxt_mode  = f_mode;
							if (hd.ok) begin
								nxt_acc = VALUE_WIDTH'(hd.value);
							end
						end
					endcase
				end
				MODE_NUM: begin
					if (hd.ok) begin
						nxt_acc = {acc_q[VALUE_WIDTH-5:0], hd.value};
					end else begin
						ent.kind0 = TK_NUMBER;
						ent.value = to_out(acc_q);
						ent.kind1 = f_kind;
						ent.cnt   = 2'd1 + {1'b0, f_has};
						nxt_mode  = f_mode;
					end
				end
				default: begin
					ent.kind0 = f_kind;
					ent.cnt   = {1'b0, f_has};
					nxt_mode  = f_mode;
					if (hd.ok) begin
						nxt_acc = VALUE_WIDTH'(hd.value);
					end
				end
			endcase
		end
	end

	assign q_push  = accept && (ent.cnt != 2'd0);
	assign q_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
		end else if (accept) begin
			mode_q <= nxt_mode;
			acc_q  <= nxt_acc;
		end
	end

endmodule

// ===== sv/qtl_fifo.sv =====
module qtl_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qtl_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output qtl_pkg::entry_t rd_entry
);
	import qtl_pkg::*;

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	assign full     = (count_q == QCW'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/qtl_back.sv =====
module qtl_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_nonempty,
	input  qtl_pkg::entry_t               q_entry,
	output logic                          q_pop,
	output logic                          token_valid,
	input  logic                          token_stall,
	output logic [3:0]                    token_kind,
	output logic [qtl_pkg::OUT_WIDTH-1:0] number_value,
	output logic                          last_of_run
);
	import qtl_pkg::*;

	logic                 valid_q;
	logic                 phase_q;
	token_kind_t          kind_q;
	logic [OUT_WIDTH-1:0] value_q;
	logic                 last_q;
	logic                 load;
	logic                 second;

	assign load   = !valid_q || !token_stall;
	assign second = (q_entry.cnt == 2'd2) && !phase_q;
	assign q_pop  = load && q_nonempty && !second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= q_nonempty;
			if (q_nonempty) begin
				phase_q <= second;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_nonempty) begin
			if (phase_q) begin
				kind_q  <= q_entry.kind1;
				value_q <= '0;
			end else begin
				kind_q  <= q_entry.kind0;
				value_q <= q_entry.value;
			end
			last_q <= !second;
		end
	end

	assign token_valid  = valid_q;
	assign token_kind   = 4'(kind_q);
	assign number_value = value_q;
	assign last_of_run  = last_q;

endmodule

// ===== sv/query_token_lexer.sv =====
// Streaming query lexer: one character per transaction on the char channel, tokens out on the
// token channel. A character is taken every cycle while the four-entry token queue has room;
// the output side sends one token per cycle while token_stall is low, so a character that
// yields two tokens (a number or bad '@' closed by another token character, or a read failure
// after a number or '@') sends them in turn. Characters that yield no token (hex digits of a
// number, an opening '@') never enter the queue. number_value carries the hex run modulo 2^32
// on number tokens and is zero otherwise; last_of_run marks the final token of one character.
module query_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        read_failed,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [3:0]  token_kind,
	output logic [31:0] number_value,
	output logic        last_of_run
);
	import qtl_pkg::*;

	logic   q_full;
	logic   q_push;
	logic   q_pop;
	logic   q_nonempty;
	entry_t wr_entry;
	entry_t rd_entry;

	qtl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.read_failed(read_failed),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (wr_entry)
	);

	qtl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_entry(wr_entry),
		.full    (q_full),
		.pop     (q_pop),
		.nonempty(q_nonempty),
		.rd_entry(rd_entry)
	);

	qtl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.q_entry     (rd_entry),
		.q_pop       (q_pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_kind  (token_kind),
		.number_value(number_value),
		.last_of_run (last_of_run)
	);

endmodule
